// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// no dependencies; the synthesis view leaves every macro empty
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

// ===== hw/rtl/itpr_pkg.sv =====
// types, codes and helpers for the infix to postfix reorder block
// no dependencies; used by every module of the block
`default_nettype none

package itpr_pkg;

   localparam int STACK_DEPTH       = 32;
   localparam int PRECEDENCE_LEVELS = 4;
   localparam int VALUE_WIDTH       = 32;
   localparam int QUEUE_DEPTH       = 2;

   localparam int LEVEL_WIDTH = 2;
   localparam int PREC_WIDTH  = 12;
   localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);

   localparam logic [PREC_WIDTH-1:0] PREC_RESET = 12'd3732;

   localparam logic [1:0] OPERATION_OPERAND  = 2'd0;
   localparam logic [1:0] OPERATION_OPERATOR = 2'd1;
   localparam logic [1:0] OPERATION_END      = 2'd2;

   localparam logic [2:0] OP_OPEN      = 3'd0;
   localparam logic [2:0] OP_CLOSE     = 3'd1;
   localparam logic [2:0] FIRST_BINARY = 3'd2;

   localparam logic [2:0] KIND_LITERAL  = 3'd0;
   localparam logic [2:0] KIND_VARIABLE = 3'd1;
   localparam logic [2:0] KIND_OPERATOR = 3'd2;
   localparam logic [2:0] KIND_END      = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNMATCHED = 2'd1;
   localparam logic [1:0] ERR_UNCLOSED  = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

   typedef struct packed {
      logic [1:0]             operation;
      logic [2:0]             operator_code;
      logic                   operand_is_variable;
      logic [VALUE_WIDTH-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [2:0]             token_kind;
      logic [2:0]             out_operator;
      logic [VALUE_WIDTH-1:0] out_value;
      logic [1:0]             error_code;
      logic                   last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_OPERAND,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_BINARY,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [2:0]             code;
      logic [LEVEL_WIDTH-1:0] level;
      logic                   is_var;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_type;

   // binding level of an operator code, clamped to the top level
   function automatic logic [LEVEL_WIDTH-1:0] level_of(
      input logic [2:0]            code,
      input logic [PREC_WIDTH-1:0] prec
   );
      logic [LEVEL_WIDTH-1:0] lvl;
      lvl = LEVEL_WIDTH'(PRECEDENCE_LEVELS - 1);
      if (code >= FIRST_BINARY) begin
         lvl = LEVEL_WIDTH'(prec >> {code - FIRST_BINARY, 1'b0});
      end
      if (int'(lvl) >= PRECEDENCE_LEVELS) begin
         lvl = LEVEL_WIDTH'(PRECEDENCE_LEVELS - 1);
      end
      return lvl;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itpr_front.sv =====
// front end: classifies each accepted item into a stack command
// depends on itpr_pkg
`default_nettype none

module itpr_front (
   input  wire logic                          req_valid,
   input  wire itpr_pkg::req_type             req_data,
   input  wire logic [itpr_pkg::PREC_WIDTH-1:0] prec,
   output logic                               cmd_valid,
   output itpr_pkg::cmd_type                  cmd_data
);

   always_comb begin
      cmd_valid       = 1'b0;
      cmd_data.kind   = itpr_pkg::CMD_OPERAND;
      cmd_data.code   = req_data.operator_code;
      cmd_data.level  = itpr_pkg::level_of(req_data.operator_code, prec);
      cmd_data.is_var = req_data.operand_is_variable;
      cmd_data.value  = req_data.operand_value;
      unique case (req_data.operation)
         itpr_pkg::OPERATION_OPERAND: begin
            cmd_valid     = req_valid;
            cmd_data.kind = itpr_pkg::CMD_OPERAND;
         end
         itpr_pkg::OPERATION_OPERATOR: begin
            cmd_valid = req_valid;
            unique case (req_data.operator_code)
               itpr_pkg::OP_OPEN:  cmd_data.kind = itpr_pkg::CMD_OPEN;
               itpr_pkg::OP_CLOSE: cmd_data.kind = itpr_pkg::CMD_CLOSE;
               default:            cmd_data.kind = itpr_pkg::CMD_BINARY;
            endcase
         end
         itpr_pkg::OPERATION_END: begin
            cmd_valid     = req_valid;
            cmd_data.kind = itpr_pkg::CMD_END;
         end
         default: begin
            // undefined operation: item is dropped
            cmd_valid = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/itpr_queue.sv =====
// short command queue between the front and back ends
// depends on itpr_pkg
`default_nettype none

module itpr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_stall,
   input  wire itpr_pkg::cmd_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_take,
   output itpr_pkg::cmd_type      pop_data
);

   localparam int PTR_WIDTH = $clog2(itpr_pkg::QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(itpr_pkg::QUEUE_DEPTH + 1);

   itpr_pkg::cmd_type      entry_ff [itpr_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign push_stall = (fill_ff == CNT_WIDTH'(itpr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && pop_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(itpr_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(itpr_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/itpr_back.sv =====
// back end: operator stack, pop sequencer and result register
// depends on itpr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module itpr_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [itpr_pkg::PREC_WIDTH-1:0] prec,
   input  wire logic                            q_valid,
   input  wire itpr_pkg::cmd_type               q_data,
   output logic                                 q_take,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output itpr_pkg::rsp_type                    rsp_data
);

   localparam int CW = itpr_pkg::COUNT_WIDTH;
   localparam int AW = itpr_pkg::ADDR_WIDTH;

   typedef enum logic {S_RUN, S_FLUSH} state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      stack_count_ff, stack_count_in;
   logic               pend_valid_ff, pend_valid_in;
   itpr_pkg::rsp_type  pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   itpr_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [2:0]         stack_mem [itpr_pkg::STACK_DEPTH];
   logic [2:0]         top_ff;
   logic [AW-1:0]      wr_addr, rd_addr;

   logic                              out_free, step_en;
   logic                              empty, full;
   logic [itpr_pkg::LEVEL_WIDTH-1:0]  top_level;
   logic                              new_valid, done, pop, push, clear;
   itpr_pkg::rsp_type                 new_r;
   logic                              out_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = (state_ff == S_RUN) && q_valid && out_free;
   assign empty     = (stack_count_ff == '0);
   assign full      = (stack_count_ff == CW'(itpr_pkg::STACK_DEPTH));
   assign top_level = itpr_pkg::level_of(top_ff, prec);
   assign q_take    = step_en && done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one stack step per cycle while the queue holds a command, the result register is free and no flush is under way
   always_comb begin
      new_valid = 1'b0;
      new_r     = '0;
      done      = 1'b0;
      pop       = 1'b0;
      push      = 1'b0;
      clear     = 1'b0;
      if (step_en) begin
         unique case (q_data.kind)
            itpr_pkg::CMD_OPERAND: begin
               new_valid        = 1'b1;
               new_r.token_kind = q_data.is_var ? itpr_pkg::KIND_VARIABLE
                                                : itpr_pkg::KIND_LITERAL;
               new_r.out_value  = q_data.value;
               done             = 1'b1;
            end
            itpr_pkg::CMD_OPEN: begin
               done = 1'b1;
               if (full) begin
                  clear            = 1'b1;
                  new_valid        = 1'b1;
                  new_r.token_kind = itpr_pkg::KIND_ERROR;
                  new_r.error_code = itpr_pkg::ERR_OVERFLOW;
               end else begin
                  push = 1'b1;
               end
            end
            itpr_pkg::CMD_CLOSE: begin
               if (empty) begin
                  new_valid        = 1'b1;
                  new_r.token_kind = itpr_pkg::KIND_ERROR;
                  new_r.error_code = itpr_pkg::ERR_UNMATCHED;
                  done             = 1'b1;
               end else if (top_ff == itpr_pkg::OP_OPEN) begin
                  pop  = 1'b1;
                  done = 1'b1;
               end else begin
                  new_valid          = 1'b1;
                  new_r.token_kind   = itpr_pkg::KIND_OPERATOR;
                  new_r.out_operator = top_ff;
                  pop                = 1'b1;
               end
            end
            itpr_pkg::CMD_BINARY: begin
               if (!empty && top_ff != itpr_pkg::OP_OPEN && top_level <= q_data.level) begin
                  new_valid          = 1'b1;
                  new_r.token_kind   = itpr_pkg::KIND_OPERATOR;
                  new_r.out_operator = top_ff;
                  pop                = 1'b1;
               end else begin
                  done = 1'b1;
                  if (full) begin
                     clear            = 1'b1;
                     new_valid        = 1'b1;
                     new_r.token_kind = itpr_pkg::KIND_ERROR;
                     new_r.error_code = itpr_pkg::ERR_OVERFLOW;
                  end else begin
                     push = 1'b1;
                  end
               end
            end
            itpr_pkg::CMD_END: begin
               if (empty) begin
                  new_valid        = 1'b1;
                  new_r.token_kind = itpr_pkg::KIND_END;
                  done             = 1'b1;
               end else if (top_ff == itpr_pkg::OP_OPEN) begin
                  clear            = 1'b1;
                  new_valid        = 1'b1;
                  new_r.token_kind = itpr_pkg::KIND_ERROR;
                  new_r.error_code = itpr_pkg::ERR_UNCLOSED;
                  done             = 1'b1;
               end else begin
                  new_valid          = 1'b1;
                  new_r.token_kind   = itpr_pkg::KIND_OPERATOR;
                  new_r.out_operator = top_ff;
                  pop                = 1'b1;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      stack_count_in = stack_count_ff;
      if (clear) begin
         stack_count_in = '0;
      end else if (pop) begin
         stack_count_in = stack_count_ff - CW'(1);
      end else if (push) begin
         stack_count_in = stack_count_ff + CW'(1);
      end
      wr_addr = AW'(stack_count_ff);
      rd_addr = (stack_count_in == '0) ? '0 : AW'(stack_count_in - CW'(1));
   end

   // one result held back so the last of a run can be flagged
   always_comb begin
      out_load      = 1'b0;
      rsp_data_in   = pend_ff;
      rsp_data_in.last_of_run = 1'b0;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      state_in      = state_ff;
      if (state_ff == S_FLUSH) begin
         if (out_free) begin
            out_load                = 1'b1;
            rsp_data_in.last_of_run = 1'b1;
            pend_valid_in           = 1'b0;
            state_in                = S_RUN;
         end
      end else if (step_en) begin
         if (new_valid && pend_valid_ff) begin
            out_load      = 1'b1;
            pend_in       = new_r;
            pend_valid_in = 1'b1;
            if (done) begin
               state_in = S_FLUSH;
            end
         end else if (new_valid) begin
            if (done) begin
               out_load                = 1'b1;
               rsp_data_in             = new_r;
               rsp_data_in.last_of_run = 1'b1;
            end else begin
               pend_in       = new_r;
               pend_valid_in = 1'b1;
            end
         end else if (done && pend_valid_ff) begin
            out_load                = 1'b1;
            rsp_data_in.last_of_run = 1'b1;
            pend_valid_in           = 1'b0;
         end
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // stack memory with registered top read, write forwarded
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[wr_addr] <= q_data.code;
      end
      if (push && wr_addr == rd_addr) begin
         top_ff <= q_data.code;
      end else begin
         top_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         state_ff       <= S_RUN;
         stack_count_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   `ASSERT_NEVER(a_flush_has_pend, clock, reset, state_ff == S_FLUSH && !pend_valid_ff)
   `ASSERT_CLK(a_idle_no_pend, clock, reset, (state_ff == S_RUN && !q_valid) |-> !pend_valid_ff)
   `ASSERT_CLK(a_push_grows, clock, reset, push |=> stack_count_ff == $past(stack_count_ff) + CW'(1))
   `ASSERT_CLK(a_final_kinds_last, clock, reset, (rsp_valid_ff && (rsp_data_ff.token_kind == itpr_pkg::KIND_ERROR || rsp_data_ff.token_kind == itpr_pkg::KIND_END)) |-> rsp_data_ff.last_of_run)
   `ASSERT_NEVER(a_count_range, clock, reset, stack_count_ff > CW'(itpr_pkg::STACK_DEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/infix_to_postfix_reorder_top.sv =====
// top level of the infix to postfix reorder block: precedence register,
// front end, command queue and back end; depends on itpr_pkg and the itpr modules
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  itpr_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  itpr_pkg::rsp_type
//   csr      in         csr_write_enable     12-bit precedence map
//
// an item passes through the combinational front end into the queue, then the back end
// takes stack steps: one per operand, open, push, paren pop or end, one more per operator popped
// the back end enters a flush state when a run ends with two results still to hand over
// reset clears the stack count, queue and result valid flag; no clearing pass
// a stalled result holds the back end while the front end keeps filling the queue
`default_nettype none

module infix_to_postfix_reorder_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire itpr_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output itpr_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write_enable,
   input  wire logic [itpr_pkg::PREC_WIDTH-1:0] csr_write_data
);

   logic [itpr_pkg::PREC_WIDTH-1:0] prec_ff;
   logic                            cmd_valid;
   itpr_pkg::cmd_type               cmd_data;
   logic                            q_valid, q_take;
   itpr_pkg::cmd_type               q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= itpr_pkg::PREC_RESET;
      end else if (csr_write_enable) begin
         prec_ff <= csr_write_data;
      end
   end

   itpr_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .prec      (prec_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data)
   );

   itpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_stall (req_stall),
      .push_data  (cmd_data),
      .pop_valid  (q_valid),
      .pop_take   (q_take),
      .pop_data   (q_data)
   );

   itpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .prec      (prec_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
